// ===== design/gped_pkg.sv =====
// Shared types, register map decode and wake mask table for the GPIO edge-detect unit.
`default_nettype none
package gped_pkg;

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_PIN   = 2'd2;

  localparam logic [3:0] K_NONE   = 4'd0;
  localparam logic [3:0] K_LEVEL  = 4'd1;
  localparam logic [3:0] K_SET    = 4'd2;
  localparam logic [3:0] K_CLEAR  = 4'd3;
  localparam logic [3:0] K_DIR    = 4'd4;
  localparam logic [3:0] K_RISE   = 4'd5;
  localparam logic [3:0] K_FALL   = 4'd6;
  localparam logic [3:0] K_STATUS = 4'd7;
  localparam logic [3:0] K_ALT_LO = 4'd8;
  localparam logic [3:0] K_ALT_HI = 4'd9;

  localparam logic [7:0] PIN_COUNT_RESET = 8'd128;

  typedef struct packed {
    logic [31:0] input_level;
    logic [31:0] output_level;
    logic [31:0] direction;
    logic [31:0] rise_enable;
    logic [31:0] fall_enable;
    logic [31:0] edge_status;
    logic [31:0] alt_lo;
    logic [31:0] alt_hi;
  } bank_row_t;

  typedef struct packed {
    logic [3:0] kind;
    logic [1:0] bank;
  } dec_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [3:0]  kind;
    logic        ok;
    logic [1:0]  bank;
    logic [31:0] write_data;
    logic [4:0]  bit_idx;
    logic        pin_level;
    logic        cpu_halted;
  } req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        wake_request;
    logic        level_read_pulse;
    logic [1:0]  drive_bank;
    logic [31:0] drive_level;
    logic [31:0] drive_changed;
    logic        bad_access;
  } rsp_t;

  function automatic dec_t decode_offset(input logic [8:0] off);
    dec_t d;
    d = '{kind: K_NONE, bank: 2'd0};
    unique case (off)
      9'h000: d = '{kind: K_LEVEL,  bank: 2'd0};
      9'h004: d = '{kind: K_LEVEL,  bank: 2'd1};
      9'h008: d = '{kind: K_LEVEL,  bank: 2'd2};
      9'h100: d = '{kind: K_LEVEL,  bank: 2'd3};
      9'h018: d = '{kind: K_SET,    bank: 2'd0};
      9'h01c: d = '{kind: K_SET,    bank: 2'd1};
      9'h020: d = '{kind: K_SET,    bank: 2'd2};
      9'h118: d = '{kind: K_SET,    bank: 2'd3};
      9'h024: d = '{kind: K_CLEAR,  bank: 2'd0};
      9'h028: d = '{kind: K_CLEAR,  bank: 2'd1};
      9'h02c: d = '{kind: K_CLEAR,  bank: 2'd2};
      9'h124: d = '{kind: K_CLEAR,  bank: 2'd3};
      9'h00c: d = '{kind: K_DIR,    bank: 2'd0};
      9'h010: d = '{kind: K_DIR,    bank: 2'd1};
      9'h014: d = '{kind: K_DIR,    bank: 2'd2};
      9'h10c: d = '{kind: K_DIR,    bank: 2'd3};
      9'h030: d = '{kind: K_RISE,   bank: 2'd0};
      9'h034: d = '{kind: K_RISE,   bank: 2'd1};
      9'h038: d = '{kind: K_RISE,   bank: 2'd2};
      9'h130: d = '{kind: K_RISE,   bank: 2'd3};
      9'h03c: d = '{kind: K_FALL,   bank: 2'd0};
      9'h040: d = '{kind: K_FALL,   bank: 2'd1};
      9'h044: d = '{kind: K_FALL,   bank: 2'd2};
      9'h13c: d = '{kind: K_FALL,   bank: 2'd3};
      9'h048: d = '{kind: K_STATUS, bank: 2'd0};
      9'h04c: d = '{kind: K_STATUS, bank: 2'd1};
      9'h050: d = '{kind: K_STATUS, bank: 2'd2};
      9'h148: d = '{kind: K_STATUS, bank: 2'd3};
      9'h054: d = '{kind: K_ALT_LO, bank: 2'd0};
      9'h05c: d = '{kind: K_ALT_LO, bank: 2'd1};
      9'h064: d = '{kind: K_ALT_LO, bank: 2'd2};
      9'h06c: d = '{kind: K_ALT_LO, bank: 2'd3};
      9'h058: d = '{kind: K_ALT_HI, bank: 2'd0};
      9'h060: d = '{kind: K_ALT_HI, bank: 2'd1};
      9'h068: d = '{kind: K_ALT_HI, bank: 2'd2};
      9'h070: d = '{kind: K_ALT_HI, bank: 2'd3};
      default: d = '{kind: K_NONE, bank: 2'd0};
    endcase
    return d;
  endfunction

  function automatic logic [31:0] wake_mask(input logic [1:0] bank);
    logic [31:0] m;
    unique case (bank)
      2'd0: m = 32'h8003fe1b;
      2'd1: m = 32'h002001fc;
      2'd2: m = 32'hec080000;
      2'd3: m = 32'h0012007f;
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

// ===== design/gped_mem.sv =====
// Per-bank state memory: one row per bank, registered read, per-row valid bits.
`default_nettype none
module gped_mem #(
  parameter int DEPTH = 4,
  parameter int IDX_W = 2
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        rd_en,
  input  wire  [IDX_W-1:0]           rd_idx,
  output gped_pkg::bank_row_t        rd_row,
  input  wire                        wr_en,
  input  wire  [IDX_W-1:0]           wr_idx,
  input  gped_pkg::bank_row_t        wr_row
);

  gped_pkg::bank_row_t mem [DEPTH];
  logic [DEPTH-1:0]    valid_r;
  gped_pkg::bank_row_t rd_row_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_idx] <= 1'b1;
    end
  end

  // never-written rows read as their reset value of zero
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_row_r <= valid_r[rd_idx] ? mem[rd_idx] : '0;
    end
  end

  assign rd_row = rd_row_r;

endmodule
`default_nettype wire

// ===== design/gped_update.sv =====
// Read-modify logic: applies one transaction to a bank row and forms the result.
`default_nettype none
module gped_update (
  input  gped_pkg::req_t      req,
  input  gped_pkg::bank_row_t row,
  output gped_pkg::bank_row_t row_nxt,
  output gped_pkg::rsp_t      rsp
);

  logic [31:0] m;
  logic [31:0] lv_old;
  logic [31:0] lv_new;

  always_comb begin
    m       = 32'd1 << req.bit_idx;
    row_nxt = row;
    rsp     = '0;
    unique case (req.opcode)
      gped_pkg::OP_READ: begin
        if (!req.ok) begin
          rsp.bad_access = 1'b1;
        end else begin
          unique case (req.kind)
            gped_pkg::K_LEVEL: begin
              rsp.read_data = (row.output_level & row.direction) |
                              (row.input_level & ~row.direction);
              rsp.level_read_pulse = 1'b1;
            end
            gped_pkg::K_DIR:    rsp.read_data = row.direction;
            gped_pkg::K_RISE:   rsp.read_data = row.rise_enable;
            gped_pkg::K_FALL:   rsp.read_data = row.fall_enable;
            gped_pkg::K_STATUS: rsp.read_data = row.edge_status;
            gped_pkg::K_ALT_LO: rsp.read_data = row.alt_lo;
            gped_pkg::K_ALT_HI: rsp.read_data = row.alt_hi;
            default:            rsp.bad_access = 1'b1;
          endcase
        end
      end
      gped_pkg::OP_WRITE: begin
        if (!req.ok) begin
          rsp.bad_access = 1'b1;
        end else begin
          unique case (req.kind)
            gped_pkg::K_SET:    row_nxt.output_level = row.output_level | req.write_data;
            gped_pkg::K_CLEAR:  row_nxt.output_level = row.output_level & ~req.write_data;
            gped_pkg::K_DIR:    row_nxt.direction    = req.write_data;
            gped_pkg::K_RISE:   row_nxt.rise_enable  = req.write_data;
            gped_pkg::K_FALL:   row_nxt.fall_enable  = req.write_data;
            gped_pkg::K_STATUS: row_nxt.edge_status  = row.edge_status & ~req.write_data;
            gped_pkg::K_ALT_LO: row_nxt.alt_lo       = req.write_data;
            gped_pkg::K_ALT_HI: row_nxt.alt_hi       = req.write_data;
            default:            rsp.bad_access       = 1'b1;
          endcase
        end
      end
      gped_pkg::OP_PIN: begin
        if (!req.ok) begin
          rsp.bad_access = 1'b1;
        end else begin
          if (req.pin_level) begin
            row_nxt.edge_status = row.edge_status |
              (row.rise_enable & m & ~row.input_level & ~row.direction);
            row_nxt.input_level = row.input_level | m;
          end else begin
            row_nxt.edge_status = row.edge_status |
              (row.fall_enable & m & row.input_level & ~row.direction);
            row_nxt.input_level = row.input_level & ~m;
          end
          rsp.wake_request = req.cpu_halted &
            (|(m & ~row.direction & gped_pkg::wake_mask(req.bank)));
        end
      end
      default: rsp.bad_access = 1'b1;
    endcase
    lv_old = row.output_level & row.direction;
    lv_new = row_nxt.output_level & row_nxt.direction;
    rsp.drive_bank    = req.bank;
    rsp.drive_level   = lv_new;
    rsp.drive_changed = lv_new ^ lv_old;
  end

endmodule
`default_nettype wire

// ===== design/gpio_controller_edge_detect_unit.sv =====
// Top level of the GPIO controller with edge-detect interrupts.
// Usage:
//   Input channel: drive in_* and raise start; a transaction is taken at a clock
//   edge where start is high and busy is low. Opcodes are bus read, bus write
//   and external pin level event.
//   Result channel: out_strobe marks the single cycle that carries the result;
//   the receiver cannot stall, so the result must be sampled in that cycle.
//   Configuration: cfg_we with cfg_wdata writes pin_count; write only while idle.
// Timing:
//   Cycle after acceptance: the bank row is read from the state memory
//   (registered read) and modified; the row is written back at the end of it.
//   out_strobe is high in the following cycle.
//   busy is high for the one read-modify-write cycle, so a new transaction is
//   not taken until that transaction has finished its read-modify-write.
// Reset (rst_n low, synchronous): all bank rows read as zero, pin_count is 128,
//   interrupt levels are low, no result is pending.
`default_nettype none
module gpio_controller_edge_detect_unit #(
  parameter int BANKS = 4
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         start,
  output logic        busy,
  input  wire  [1:0]  in_opcode,
  input  wire  [8:0]  in_offset,
  input  wire  [31:0] in_write_data,
  input  wire  [6:0]  in_pin,
  input  wire         in_pin_level,
  input  wire         in_cpu_halted,
  input  wire         cfg_we,
  input  wire  [7:0]  cfg_wdata,
  output logic        out_strobe,
  output logic [31:0] out_read_data,
  output logic        out_irq_pin0,
  output logic        out_irq_pin1,
  output logic        out_irq_others,
  output logic        out_wake_request,
  output logic        out_level_read_pulse,
  output logic [1:0]  out_drive_bank,
  output logic [31:0] out_drive_level,
  output logic [31:0] out_drive_changed,
  output logic        out_bad_access
);

  localparam int IDX_W = (BANKS > 1) ? $clog2(BANKS) : 1;

  logic                busy_r;
  logic                strobe_r;
  logic [7:0]          pin_count_r;
  gped_pkg::req_t      req_r;
  gped_pkg::req_t      req_nxt;
  gped_pkg::dec_t      dec;
  logic                accept;
  logic                pin_ok;
  gped_pkg::bank_row_t rd_row;
  gped_pkg::bank_row_t row_nxt;
  gped_pkg::rsp_t      rsp;
  gped_pkg::rsp_t      rsp_r;
  logic [BANKS-1:0]    nz_r;
  logic [BANKS-1:0]    nz_nxt;
  logic [1:0]          st01_r;
  logic [1:0]          st01_nxt;
  logic                irq0_r;
  logic                irq1_r;
  logic                irqo_r;

  assign accept = start & ~busy_r;
  assign dec    = gped_pkg::decode_offset(in_offset);
  assign pin_ok = ({1'b0, in_pin} < pin_count_r) && ({30'd0, in_pin[6:5]} < 32'(BANKS));

  always_comb begin
    req_nxt            = '0;
    req_nxt.opcode     = in_opcode;
    req_nxt.kind       = dec.kind;
    req_nxt.write_data = in_write_data;
    req_nxt.bit_idx    = in_pin[4:0];
    req_nxt.pin_level  = in_pin_level;
    req_nxt.cpu_halted = in_cpu_halted;
    unique case (in_opcode)
      gped_pkg::OP_READ, gped_pkg::OP_WRITE: begin
        req_nxt.ok = (dec.kind != gped_pkg::K_NONE) && ({30'd0, dec.bank} < 32'(BANKS));
        req_nxt.bank = req_nxt.ok ? dec.bank : 2'd0;
      end
      gped_pkg::OP_PIN: begin
        req_nxt.ok   = pin_ok;
        req_nxt.bank = pin_ok ? in_pin[6:5] : 2'd0;
      end
      default: begin
        req_nxt.ok   = 1'b0;
        req_nxt.bank = 2'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      strobe_r    <= 1'b0;
      pin_count_r <= gped_pkg::PIN_COUNT_RESET;
      nz_r        <= '0;
      st01_r      <= '0;
      irq0_r      <= 1'b0;
      irq1_r      <= 1'b0;
      irqo_r      <= 1'b0;
    end else begin
      busy_r   <= accept;
      strobe_r <= busy_r;
      if (cfg_we) begin
        pin_count_r <= cfg_wdata;
      end
      if (busy_r) begin
        nz_r   <= nz_nxt;
        st01_r <= st01_nxt;
        irq0_r <= st01_nxt[0];
        irq1_r <= st01_nxt[1];
        irqo_r <= |nz_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= req_nxt;
    end
    if (busy_r) begin
      rsp_r <= rsp;
    end
  end

  // interrupt summary: bank 0 bits 0 and 1 kept apart, any-other-bit per bank
  always_comb begin
    nz_nxt   = nz_r;
    st01_nxt = st01_r;
    if (req_r.ok) begin
      if (req_r.bank == 2'd0) begin
        st01_nxt  = row_nxt.edge_status[1:0];
        nz_nxt[0] = |row_nxt.edge_status[31:2];
      end else begin
        nz_nxt[req_r.bank[IDX_W-1:0]] = |row_nxt.edge_status;
      end
    end
  end

  gped_mem #(
    .DEPTH (BANKS),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_en  (accept),
    .rd_idx (req_nxt.bank[IDX_W-1:0]),
    .rd_row (rd_row),
    .wr_en  (busy_r & req_r.ok),
    .wr_idx (req_r.bank[IDX_W-1:0]),
    .wr_row (row_nxt)
  );

  gped_update u_update (
    .req     (req_r),
    .row     (rd_row),
    .row_nxt (row_nxt),
    .rsp     (rsp)
  );

  assign busy                 = busy_r;
  assign out_strobe           = strobe_r;
  assign out_read_data        = rsp_r.read_data;
  assign out_irq_pin0         = irq0_r;
  assign out_irq_pin1         = irq1_r;
  assign out_irq_others       = irqo_r;
  assign out_wake_request     = rsp_r.wake_request;
  assign out_level_read_pulse = rsp_r.level_read_pulse;
  assign out_drive_bank       = rsp_r.drive_bank;
  assign out_drive_level      = rsp_r.drive_level;
  assign out_drive_changed    = rsp_r.drive_changed;
  assign out_bad_access       = rsp_r.bad_access;

endmodule
`default_nettype wire

// ===== design/gped_checker.sv =====
// Port-level checker for the GPIO edge-detect unit, bound to the top level.
`default_nettype none
module gped_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        start,
  input wire        busy,
  input wire        out_strobe,
  input wire        out_wake_request,
  input wire        out_level_read_pulse,
  input wire        out_bad_access
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  a_busy_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> out_strobe && !busy)
    else $error("result strobe missing after busy cycle");

  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result strobe without a transaction in flight");

  a_pulse_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_level_read_pulse || out_wake_request) |-> !out_bad_access)
    else $error("level read or wake flagged on a bad access");

endmodule

bind gpio_controller_edge_detect_unit gped_checker u_gped_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .start                (start),
  .busy                 (busy),
  .out_strobe           (out_strobe),
  .out_wake_request     (out_wake_request),
  .out_level_read_pulse (out_level_read_pulse),
  .out_bad_access       (out_bad_access)
);
`default_nettype wire
